FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the gated RMS norm row block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

FILE: rtl/core/grn_pkg.sv
// ---------------------------------------------------------------------------
// grn_pkg
// Types, constants and arithmetic helpers of the gated RMS norm row block.
// ---------------------------------------------------------------------------
package grn_pkg;

    localparam int MAX_ROW_DEF = 64;
    localparam int DATA_W      = 16;
    localparam int EPS_W       = 24;
    localparam int LEN_W       = 7;
    localparam int SUM_W       = 38;
    localparam int NUM_W       = 64;
    localparam int DEN_W       = 33;
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 68;
    localparam int STEP_W      = 5;
    localparam int SQRT_STEPS  = 32;
    localparam int EXP_STEPS   = 16;
    localparam int SIG_W       = 17;

    typedef enum logic [1:0] {
        REG_EPSILON,
        REG_ACTIVATION,
        REG_USE_WEIGHT,
        REG_ROW_LENGTH
    } cfg_reg_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MEAN,
        CMD_RECIP,
        CMD_SQRT_INIT,
        CMD_SQRT_STEP,
        CMD_READ,
        CMD_EXP_INIT,
        CMD_EXP_STEP,
        CMD_SIG_DIV,
        CMD_SIG_SET,
        CMD_MUL_XR,
        CMD_N_XR,
        CMD_MUL_W,
        CMD_N_W,
        CMD_MUL_GS,
        CMD_GS_SET,
        CMD_MUL_ACT,
        CMD_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [STEP_W-1:0]   step;
        logic                last;
    } dp_cmd_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_MEAN,
        S_MEAN_WAIT,
        S_RECIP_WAIT,
        S_SQRT,
        S_READ,
        S_EXP_INIT,
        S_EXP,
        S_SIG_DIV,
        S_SIG_WAIT,
        S_MUL_XR,
        S_N_XR,
        S_MUL_W,
        S_N_W,
        S_MUL_GS,
        S_GS_SET,
        S_MUL_ACT,
        S_EMIT
    } ctrl_state_t;

    // exp(-2^(k-12)) in Q0.31, each entry the rounded square of the one before
    typedef logic [30:0] t_tab_t [EXP_STEPS];

    function automatic t_tab_t make_t_tab();
        t_tab_t      tab;
        logic [63:0] t;
        int          k;
        t = 64'd2146959424;
        for (k = 0; k < EXP_STEPS; k++)
        begin
            tab[k] = t[30:0];
            t = (t * t + (64'd1 << 30)) >> 31;
        end
        return tab;
    endfunction

    localparam t_tab_t T_TAB = make_t_tab();

    localparam logic signed [PROD_W-1:0] N_MAX = 68'sh7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] Y_MAX = 68'sh7FFF;
    localparam logic signed [PROD_W-1:0] Y_MIN = -68'sh8000;

    // round half away from zero, divide by 2^sh
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              sh
    );
        logic [PROD_W-1:0] m;
        m = v[PROD_W-1] ? $unsigned(-v) : $unsigned(v);
        m = (m + (PROD_W'(1) << (sh - 1))) >> sh;
        return v[PROD_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] clamp_n(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > N_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < -N_MAX)
            r = -32'sh7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > Y_MAX)
            r = 16'sh7FFF;
        else if (v < Y_MIN)
            r = -16'sh8000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/grn_div.sv
// ---------------------------------------------------------------------------
// grn_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// mean, reciprocal and sigmoid steps.
// ---------------------------------------------------------------------------
module grn_div
    import grn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule

FILE: rtl/core/grn_ctrl.sv
// ---------------------------------------------------------------------------
// grn_ctrl
// Sequencer: row fill, rstd computation and per-element emission.
// ---------------------------------------------------------------------------
module grn_ctrl
    import grn_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEF,
    parameter int IDX_W   = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1,
    parameter int CNT_W   = $clog2(MAX_ROW + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    output logic             res_valid,
    input  logic             res_stall,
    input  logic [LEN_W-1:0] row_length,
    input  logic             use_weight,
    input  logic             div_done,
    output dp_cmd_t          cmd,
    output logic [IDX_W-1:0] addr,
    output logic [CNT_W-1:0] count
);

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  len_eff;
    logic [CNT_W:0]    fill_inc;
    logic [CNT_W-1:0]  idx_inc;
    logic              out_free;
    logic              out_load;
    logic              last;

    always_comb
    begin
        if (row_length == '0)
            len_eff = CNT_W'(1);
        else if (row_length > LEN_W'(MAX_ROW))
            len_eff = CNT_W'(MAX_ROW);
        else
            len_eff = row_length[CNT_W-1:0];
    end

    assign fill_inc = {1'b0, fill_reg} + 1'b1;
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign last     = idx_inc == fill_reg;
    assign out_free = !out_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            fill_reg      <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cmd.op     = CMD_NONE;
        cmd.step   = step_reg;
        cmd.last   = last;
        addr       = fill_reg[IDX_W-1:0];
        item_stall = 1'b1;
        out_load   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.op    = CMD_LOAD;
                    fill_next = fill_inc[CNT_W-1:0];
                    if (fill_inc >= {1'b0, len_eff})
                        state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.op     = CMD_MEAN;
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    cmd.op     = CMD_RECIP;
                    state_next = S_RECIP_WAIT;
                end
            end
            S_RECIP_WAIT:
            begin
                if (div_done)
                begin
                    cmd.op     = CMD_SQRT_INIT;
                    step_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op    = CMD_SQRT_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                addr       = idx_reg;
                cmd.op     = CMD_READ;
                state_next = S_EXP_INIT;
            end
            S_EXP_INIT:
            begin
                cmd.op     = CMD_EXP_INIT;
                step_next  = '0;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                cmd.op = CMD_EXP_STEP;
                if (step_reg == STEP_W'(EXP_STEPS - 1))
                    state_next = S_SIG_DIV;
                else
                    step_next = step_reg + 1'b1;
            end
            S_SIG_DIV:
            begin
                cmd.op     = CMD_SIG_DIV;
                state_next = S_SIG_WAIT;
            end
            S_SIG_WAIT:
            begin
                if (div_done)
                begin
                    cmd.op     = CMD_SIG_SET;
                    state_next = S_MUL_XR;
                end
            end
            S_MUL_XR:
            begin
                cmd.op     = CMD_MUL_XR;
                state_next = S_N_XR;
            end
            S_N_XR:
            begin
                cmd.op     = CMD_N_XR;
                state_next = use_weight ? S_MUL_W : S_MUL_GS;
            end
            S_MUL_W:
            begin
                cmd.op     = CMD_MUL_W;
                state_next = S_N_W;
            end
            S_N_W:
            begin
                cmd.op     = CMD_N_W;
                state_next = S_MUL_GS;
            end
            S_MUL_GS:
            begin
                cmd.op     = CMD_MUL_GS;
                state_next = S_GS_SET;
            end
            S_GS_SET:
            begin
                cmd.op     = CMD_GS_SET;
                state_next = S_MUL_ACT;
            end
            S_MUL_ACT:
            begin
                cmd.op     = CMD_MUL_ACT;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.op   = CMD_EMIT;
                    out_load = 1'b1;
                    if (last)
                    begin
                        fill_next  = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_inc[IDX_W-1:0];
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && res_stall);
    assign res_valid      = out_valid_reg;
    assign count          = fill_reg;

endmodule

FILE: rtl/core/grn_dp.sv
// ---------------------------------------------------------------------------
// grn_dp
// Datapath: row buffers, sum of squares, divider, square root, exp chain
// and one shared multiplier for the exp, normalize and gate steps.
// ---------------------------------------------------------------------------
module grn_dp
    import grn_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEF,
    parameter int IDX_W   = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1,
    parameter int CNT_W   = $clog2(MAX_ROW + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic [IDX_W-1:0]         addr,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] gate_value,
    input  logic signed [DATA_W-1:0] scale,
    input  logic [EPS_W-1:0]         epsilon,
    input  logic                     activation,
    output logic                     div_done,
    output logic signed [DATA_W-1:0] result,
    output logic                     row_end
);

    logic [DATA_W-1:0] value_mem [MAX_ROW];
    logic [DATA_W-1:0] gate_mem  [MAX_ROW];
    logic [DATA_W-1:0] scale_mem [MAX_ROW];

    logic [SUM_W-1:0]          sum_reg;
    logic signed [31:0]        sq;
    logic signed [DATA_W-1:0]  x_reg, g_reg, w_reg;
    logic [NUM_W-1:0]          q_reg, res_reg, bit_reg;
    logic [NUM_W-1:0]          trial;
    logic [DATA_W-1:0]         a_reg;
    logic [DATA_W-1:0]         g_abs;
    logic [31:0]               e_reg;
    logic [PROD_W-1:0]         e_sum;
    logic [SIG_W-1:0]          s_reg;
    logic signed [31:0]        n_reg;
    logic signed [MUL_W-1:0]   gs_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [DATA_W-1:0]  result_reg;
    logic                      row_end_reg;

    logic                      div_start;
    logic [NUM_W-1:0]          div_numer;
    logic [DEN_W-1:0]          div_denom;
    logic [NUM_W-1:0]          quot;
    logic [DEN_W-1:0]          ms_sum, ms;
    logic [DEN_W-1:0]          sig_den;
    logic [NUM_W-1:0]          sig_num;
    logic signed [DATA_W-1:0]  y;

    grn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .quot  (quot),
        .done  (div_done)
    );

    assign sq      = value * value;
    assign ms_sum  = quot[DEN_W-1:0] + DEN_W'(epsilon);
    assign ms      = (ms_sum == '0) ? DEN_W'(1) : ms_sum;
    assign sig_den = DEN_W'(33'h0_8000_0000) + DEN_W'(e_reg);
    assign sig_num = ((g_reg[DATA_W-1] ? NUM_W'(e_reg) : NUM_W'(64'h8000_0000)) << 16)
                     + NUM_W'(sig_den >> 1);
    assign g_abs   = g_reg[DATA_W-1] ? $unsigned(-g_reg) : $unsigned(g_reg);
    assign trial   = res_reg + bit_reg;
    assign prod    = mul_a * mul_b;
    assign e_sum   = $unsigned(prod) + (PROD_W'(1) << 30);
    assign y       = activation ? sat16(round_shift(prod_reg, 32))
                                : sat16(round_shift(prod_reg, 20));

    always_comb
    begin
        div_start = 1'b0;
        div_numer = '0;
        div_denom = '0;
        unique case (cmd.op)
            CMD_MEAN:
            begin
                div_start = 1'b1;
                div_numer = NUM_W'(sum_reg);
                div_denom = DEN_W'(count);
            end
            CMD_RECIP:
            begin
                div_start = 1'b1;
                div_numer = NUM_W'(1) << 62;
                div_denom = ms;
            end
            CMD_SIG_DIV:
            begin
                div_start = 1'b1;
                div_numer = sig_num;
                div_denom = sig_den;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            CMD_EXP_STEP:
            begin
                mul_a = $signed({2'b00, e_reg});
                mul_b = $signed({3'b000, T_TAB[cmd.step[3:0]]});
            end
            CMD_MUL_XR:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = $signed({2'b00, res_reg[31:0]});
            end
            CMD_MUL_W:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = MUL_W'(w_reg);
            end
            CMD_MUL_GS:
            begin
                mul_a = MUL_W'(g_reg);
                mul_b = $signed({{(MUL_W - SIG_W){1'b0}}, s_reg});
            end
            CMD_MUL_ACT:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = activation ? gs_reg : $signed({{(MUL_W - SIG_W){1'b0}}, s_reg});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (cmd.op == CMD_LOAD)
            sum_reg <= sum_reg + SUM_W'($unsigned(sq));
        else if (cmd.op == CMD_MEAN)
            sum_reg <= '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LOAD)
        begin
            value_mem[addr] <= value;
            gate_mem[addr]  <= gate_value;
            scale_mem[addr] <= scale;
        end
        if (cmd.op == CMD_READ)
        begin
            x_reg <= $signed(value_mem[addr]);
            g_reg <= $signed(gate_mem[addr]);
            w_reg <= $signed(scale_mem[addr]);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CMD_SQRT_INIT:
            begin
                q_reg   <= quot;
                res_reg <= '0;
                bit_reg <= NUM_W'(1) << 62;
            end
            CMD_SQRT_STEP:
            begin
                if (q_reg >= trial)
                begin
                    q_reg   <= q_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            CMD_EXP_INIT:
            begin
                a_reg <= g_abs;
                e_reg <= 32'h8000_0000;
            end
            CMD_EXP_STEP:
            begin
                if (a_reg[cmd.step[3:0]])
                    e_reg <= e_sum[62:31];
            end
            CMD_SIG_SET:
            begin
                s_reg <= quot[SIG_W-1:0];
            end
            CMD_MUL_XR, CMD_MUL_W, CMD_MUL_GS, CMD_MUL_ACT:
            begin
                prod_reg <= prod;
            end
            CMD_N_XR:
            begin
                n_reg <= clamp_n(round_shift(prod_reg, 15));
            end
            CMD_N_W:
            begin
                n_reg <= clamp_n(round_shift(prod_reg, 12));
            end
            CMD_GS_SET:
            begin
                gs_reg <= prod_reg[MUL_W-1:0];
            end
            CMD_EMIT:
            begin
                result_reg  <= y;
                row_end_reg <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign result  = result_reg;
    assign row_end = row_end_reg;

endmodule

FILE: rtl/core/gated_rms_norm_row.sv
// ---------------------------------------------------------------------------
// gated_rms_norm_row
// Gated RMS normalization of one row: buffers a row, computes rstd, then
// emits value * rstd * optional weight * act(gate) in Q3.12 with saturation.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  item     | item_valid/item_stall| value, gate_value, scale
//  res      | res_valid/res_stall  | result, row_end
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  Load: one word per cycle while the row fills; item_stall is high in all
//  other states. Row close: mean and reciprocal divides on the shared 64-step
//  divider, then a 32-step sqrt, before the first buffer read.
//  Emit: one element at a time: buffer read, the 16-step exp chain, the sigmoid
//  divide on that same divider, then the multiply steps (weight if enabled).
//  Reset clears control, sets config defaults; row buffers are not cleared.
//  A stalled result holds; the next row loads while the last result waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gated_rms_norm_row
    import grn_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] gate_value,
    input  logic signed [DATA_W-1:0] scale,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic signed [DATA_W-1:0] result,
    output logic                     row_end,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [EPS_W-1:0]         cfg_data
);

    localparam int IDX_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int CNT_W = $clog2(MAX_ROW + 1);

    logic [EPS_W-1:0] epsilon_reg;
    logic             activation_reg;
    logic             use_weight_reg;
    logic [LEN_W-1:0] row_length_reg;

    dp_cmd_t          cmd;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] count;
    logic             div_done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg    <= EPS_W'(17);
            activation_reg <= 1'b1;
            use_weight_reg <= 1'b1;
            row_length_reg <= LEN_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EPSILON:    epsilon_reg    <= cfg_data;
                REG_ACTIVATION: activation_reg <= cfg_data[0];
                REG_USE_WEIGHT: use_weight_reg <= cfg_data[0];
                REG_ROW_LENGTH: row_length_reg <= cfg_data[LEN_W-1:0];
                default:        epsilon_reg    <= epsilon_reg;
            endcase
        end
    end

    grn_ctrl #(
        .MAX_ROW (MAX_ROW),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .row_length (row_length_reg),
        .use_weight (use_weight_reg),
        .div_done   (div_done),
        .cmd        (cmd),
        .addr       (addr),
        .count      (count)
    );

    grn_dp #(
        .MAX_ROW (MAX_ROW),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .addr       (addr),
        .count      (count),
        .value      (value),
        .gate_value (gate_value),
        .scale      (scale),
        .epsilon    (epsilon_reg),
        .activation (activation_reg),
        .div_done   (div_done),
        .result     (result),
        .row_end    (row_end)
    );

    `ASSERT_IMPLIES(a_div_done_stalls, clk, rst_n, div_done, item_stall)
    `ASSERT_IMPLIES(a_load_on_accept, clk, rst_n, cmd.op == CMD_LOAD, item_valid && !item_stall)
    `ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, cmd.op == CMD_EMIT, res_valid)

endmodule

FILE: tb/sv/tb_gated_rms_norm_row.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_gated_rms_norm_row
// Self-checking bench for the gated RMS norm row block. Rows of words are
// sent with random gaps and output stalls. A bit-exact fixed-point predictor
// of the normalization and gate math queues the expected outputs for each
// closed row, and every output word is compared against that queue.
// ---------------------------------------------------------------------------
module tb_gated_rms_norm_row;
    import grn_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] res;
        logic                     last;
    } norm_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] gate_value;
    logic signed [DATA_W-1:0] scale;
    logic                     res_valid;
    logic                     res_stall;
    logic signed [DATA_W-1:0] result;
    logic                     row_end;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [EPS_W-1:0]         cfg_data;

    // predictor state
    logic [EPS_W-1:0]         eps_q;
    logic                     swish_q;
    logic                     weight_q;
    logic [LEN_W-1:0]         len_q;
    logic signed [15:0]       val_buf [MAX_ROW_DEF];
    logic signed [15:0]       gate_buf [MAX_ROW_DEF];
    logic signed [15:0]       scale_buf [MAX_ROW_DEF];
    logic [63:0]              sq_sum;
    int                       fill;

    norm_word_t               norm_q [$];
    int                       errors;
    int                       words_sent;
    int                       words_seen;
    int                       rows_closed;
    int                       hold_cycles;
    bit                       quiet;

    gated_rms_norm_row dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .gate_value (gate_value),
        .scale      (scale),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .result     (result),
        .row_end    (row_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAIL gated_rms_norm_row");
        $finish;
    end

    function automatic longint rnd_shift(input longint v, input int sh);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip(input longint v, input longint lim_lo,
                                    input longint lim_hi);
        return (v < lim_lo) ? lim_lo : ((v > lim_hi) ? lim_hi : v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] q);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (q >= r + b)
            begin
                q = q - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint sigmoid16(input longint g);
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] t;
        logic [63:0] den;
        logic [63:0] num;
        a = (g < 0) ? 64'(-g) : 64'(g);
        e = 64'd1 << 31;
        t = 64'd2146959424;
        for (int k = 0; k < 16; k++)
        begin
            if (a[k])
                e = (e * t + (64'd1 << 30)) >> 31;
            t = (t * t + (64'd1 << 30)) >> 31;
        end
        den = (64'd1 << 31) + e;
        num = ((g >= 0) ? (64'd1 << 31) : e) << 16;
        return longint'((num + den / 2) / den);
    endfunction

    // closes the buffered row and queues its normalized words
    function automatic void close_row();
        logic [63:0] ms;
        logic [63:0] rstd;
        longint      g;
        longint      s;
        longint      n;
        longint      y;
        norm_word_t  w;
        ms = sq_sum / fill + eps_q;
        if (ms == 0)
            ms = 1;
        rstd = int_sqrt((64'd1 << 62) / ms);
        for (int i = 0; i < fill; i++)
        begin
            g = gate_buf[i];
            s = sigmoid16(g);
            n = clip(rnd_shift(longint'(val_buf[i]) * longint'(rstd), 15),
                     -2147483647, 2147483647);
            if (weight_q)
                n = clip(rnd_shift(n * longint'(scale_buf[i]), 12),
                         -2147483647, 2147483647);
            if (swish_q)
                y = rnd_shift(n * (g * s), 32);
            else
                y = rnd_shift(n * s, 20);
            w.res  = 16'(clip(y, -32768, 32767));
            w.last = (i + 1 == fill);
            norm_q.push_back(w);
        end
        rows_closed++;
        sq_sum = 0;
        fill   = 0;
    endfunction

    function automatic void accept_word(input logic signed [15:0] v,
                                        input logic signed [15:0] g,
                                        input logic signed [15:0] s);
        int lim;
        lim = (len_q < 1) ? 1 : ((len_q > MAX_ROW_DEF) ? MAX_ROW_DEF : int'(len_q));
        if (fill >= MAX_ROW_DEF)
            fill = MAX_ROW_DEF - 1;
        val_buf[fill]   = v;
        gate_buf[fill]  = g;
        scale_buf[fill] = s;
        sq_sum = sq_sum + 64'(longint'(v) * longint'(v));
        fill++;
        words_sent++;
        if (fill >= lim)
            close_row();
    endfunction

    task automatic send_word(input logic signed [15:0] v, input logic signed [15:0] g,
                             input logic signed [15:0] s);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        gate_value <= g;
        scale      <= s;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        accept_word(v, g, s);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (norm_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [EPS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_EPSILON:    eps_q    = data;
            REG_ACTIVATION: swish_q  = data[0];
            REG_USE_WEIGHT: weight_q = data[0];
            REG_ROW_LENGTH: len_q    = data[LEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [EPS_W-1:0] eps, input bit act,
                              input bit wgt, input logic [LEN_W-1:0] len);
        write_reg(REG_EPSILON, eps);
        write_reg(REG_ACTIVATION, EPS_W'(act));
        write_reg(REG_USE_WEIGHT, EPS_W'(wgt));
        write_reg(REG_ROW_LENGTH, EPS_W'(len));
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 255)) - 16'sd128;
            1:       return 16'($urandom_range(0, 16383)) - 16'sd8192;
            default: return 16'($urandom);
        endcase
    endfunction

    // output checker and receiver stall generator
    initial
    begin
        int         wait_left;
        norm_word_t w;
        wait_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                words_seen++;
                if (norm_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: result %0d row_end %0b", result, row_end);
                end
                else
                begin
                    w = norm_q.pop_front();
                    if (result !== w.res || row_end !== w.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch word %0d: result exp %0d got %0d, row_end exp %0b got %0b",
                                     words_seen, w.res, result, w.last, row_end);
                    end
                end
                wait_left = quiet ? 0 : $urandom_range(0, 18);
            end
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles--;
            end
            else if (wait_left > 0)
            begin
                res_stall <= 1'b1;
                wait_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    task automatic test_extremes();
        logic signed [15:0] ext [4];
        ext = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh0001};
        set_config(24'd17, 1'b1, 1'b1, 7'd4);
        for (int i = 0; i < 4; i++)
            send_word(ext[i], ext[3 - i], ext[(i + 1) % 4]);
        for (int i = 0; i < 4; i++)
            send_word(ext[(i + 2) % 4], ext[i], -16'sh8000);
        wait_idle();
        set_config(24'hFFFFFF, 1'b0, 1'b0, 7'd4);
        for (int i = 0; i < 4; i++)
            send_word(ext[i], ext[i], ext[i]);
        wait_idle();
    endtask

    task automatic test_row_length_edges();
        set_config(24'd0, 1'b0, 1'b1, 7'd0);
        send_word(16'sh1000, 16'sh7FFF, 16'sh1000);
        send_word(-16'sh0400, -16'sh8000, 16'sh7FFF);
        wait_idle();
        // zero mean square with zero epsilon
        write_reg(REG_ROW_LENGTH, 24'd2);
        send_word(16'sh0000, 16'sh1000, 16'sh1000);
        send_word(16'sh0000, -16'sh1000, 16'sh1000);
        wait_idle();
    endtask

    task automatic test_shrink_mid_row();
        set_config(24'd4096, 1'b1, 1'b1, 7'd8);
        repeat (5)
            send_word(rand_elem(), rand_elem(), rand_elem());
        wait_idle();
        write_reg(REG_ROW_LENGTH, 24'd3);
        send_word(rand_elem(), rand_elem(), rand_elem());
        wait_idle();
    endtask

    task automatic test_random_rows(input int target);
        int                len;
        int                rows;
        logic [LEN_W-1:0]  reg_len;
        logic [EPS_W-1:0]  eps;
        bit                big_done;
        big_done = 0;
        while (words_sent < target)
        begin
            case ($urandom_range(0, 5))
                0:       eps = 24'd0;
                1:       eps = 24'hFFFFFF;
                2:       eps = 24'($urandom_range(0, 4095));
                default: eps = 24'($urandom);
            endcase
            if (!big_done && words_sent > target / 2)
            begin
                reg_len  = 7'($urandom_range(65, 127));
                big_done = 1;
            end
            else if ($urandom_range(0, 9) == 0)
                reg_len = 7'($urandom_range(16, 64));
            else
                reg_len = 7'($urandom_range(1, 8));
            len   = (reg_len > MAX_ROW_DEF) ? MAX_ROW_DEF : int'(reg_len);
            rows  = (len > 8) ? 1 : $urandom_range(1, 4);
            quiet = ($urandom_range(0, 3) == 0);
            set_config(eps, 1'($urandom), 1'($urandom), reg_len);
            repeat (rows * len)
                send_word(rand_elem(), rand_elem(), rand_elem());
            wait_idle();
        end
        quiet = 0;
    endtask

    task automatic test_backpressure();
        set_config(24'd300, 1'b1, 1'b1, 7'd8);
        quiet       = 1;
        hold_cycles = 3000;
        repeat (24)
            send_word(rand_elem(), rand_elem(), rand_elem());
        wait_idle();
        quiet = 0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        value       = '0;
        gate_value  = '0;
        scale       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        eps_q       = 24'd17;
        swish_q     = 1'b1;
        weight_q    = 1'b1;
        len_q       = 7'd64;
        sq_sum      = 0;
        fill        = 0;
        errors      = 0;
        words_sent  = 0;
        words_seen  = 0;
        rows_closed = 0;
        hold_cycles = 0;
        quiet       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_extremes();
        test_row_length_edges();
        test_shrink_mid_row();
        test_random_rows(words_sent + 200);
        test_backpressure();

        if (norm_q.size() != 0)
            errors++;
        $display("Sent %0d row elements in %0d rows, checked %0d output words, %0d errors.",
                 words_sent, rows_closed, words_seen, errors);
        if (errors == 0)
            $display("PASS gated_rms_norm_row");
        else
            $display("FAIL gated_rms_norm_row");
        $finish;
    end

endmodule
